// ===== rtl/iht_pkg.sv =====
// Package for the indexed heap timer: request codes, status codes, sizes.
// No dependencies.
package iht_pkg;
   localparam int HeapCapacity = 64;
   localparam int IdSpace      = 256;
   localparam int TimeWidth    = 32;

   localparam logic [1:0] REQ_ADD  = 2'd0;
   localparam logic [1:0] REQ_DEL  = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;
   localparam logic [1:0] REQ_FIRE = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
endpackage

// ===== rtl/indexed_heap_timer_unit.sv =====
// Indexed binary min-heap timer: top level with heap and position memories.
// Depends on iht_pkg.
//
// Usage: requests arrive as beats on the req_ channel (add/adjust, delete,
// tick, fire). Results leave on the rsp_ channel; add, delete and fire give
// one beat, a tick gives one beat per expired timer (rsp_tlast on the final
// one) or a single non-firing beat when nothing expired. Every beat of a
// request carries the count and next delay of the heap after the request.
// The heap lives in a synchronous memory of HEAP_CAPACITY entries and the
// id-to-position map in a second one of ID_SPACE entries; both have
// registered reads. A sift step reads the parent or children, then compares
// and writes both slots. A tick first pops every expired root and then sends
// its beats, each read back in S_FIN and offered in S_OUT, holding while the
// receiver stalls. One request is in flight at a time; req_tready is high
// only when the engine is idle.
// At reset the presence bits and the entry count clear at once; the memories
// need no clearing pass. When the receiver stalls, the engine holds in its
// output state until the result beat is taken.
module indexed_heap_timer_unit #(
   parameter int HEAP_CAPACITY = iht_pkg::HeapCapacity,
   parameter int ID_SPACE      = iht_pkg::IdSpace,
   parameter int TIME_WIDTH    = iht_pkg::TimeWidth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // timer_id[7:0], expire_time[39:8], now_time[71:40]
   input  logic [1:0]  req_tuser,  // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // fired_id[7:0], status[9:8], timer_count[16:10],
                                   // next_delay[48:17], zero pad[55:49]
   output logic [0:0]  rsp_tuser,  // fired_valid[0]
   output logic        rsp_tlast
);
   localparam int PW = $clog2(HEAP_CAPACITY + 1);
   localparam int AW = $clog2(HEAP_CAPACITY);
   localparam int IW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
   localparam int EW = TIME_WIDTH + IW;

   localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RDP = 4'd2, S_SETUP = 4'd3,
      S_DRD = 4'd4, S_DCMP = 4'd5, S_URD = 4'd6, S_UCMP = 4'd7, S_WR = 4'd8,
      S_TOPRD = 4'd9, S_TOPCHK = 4'd10, S_OUT = 4'd11, S_FIN = 4'd12, S_LASTRD = 4'd13;

   logic [EW-1:0] heap_mem [HEAP_CAPACITY];
   logic [AW-1:0] pos_mem  [ID_SPACE];
   logic [ID_SPACE-1:0] present_ff, present_in;
   logic [PW-1:0] count_ff, count_in;
   logic [3:0]    state_ff, state_in;

   logic [1:0]  req_ff, req_in;
   logic [7:0]  rid_ff, rid_in;
   logic [TIME_WIDTH-1:0] exp_ff, exp_in, now_ff, now_in;
   logic [1:0]  status_ff, status_in;
   logic        fv_ff, fv_in;
   logic [7:0]  fid_ff, fid_in;
   logic        more_ff, more_in;      // another beat of this tick follows
   logic        fired_any_ff, fired_any_in;
   // start_ff: slot of the earliest popped entry of a tick, then the next one to send
   logic [AW-1:0] i_ff, i_in, start_ff, start_in;
   logic [EW-1:0] cur_ff, cur_in;      // entry being sifted
   logic        moved_ff, moved_in, up_ff, up_in;
   logic [EW-1:0] top_ff, top_in;

   // memory ports
   logic          ha_re, hb_re, hw0, hw1;
   logic [AW-1:0] ha_addr, hb_addr, hw0_addr, hw1_addr;
   logic [EW-1:0] ha_q, hb_q, hw0_d, hw1_d;
   logic          pw0, pw1;
   logic [IW-1:0] p_raddr, pw0_addr, pw1_addr;
   logic [AW-1:0] p_q, pw0_d, pw1_d;

   always_ff @(posedge clock) begin
      if (ha_re) ha_q <= heap_mem[ha_addr];
      if (hb_re) hb_q <= heap_mem[hb_addr];
      if (hw0) heap_mem[hw0_addr] <= hw0_d;
      if (hw1) heap_mem[hw1_addr] <= hw1_d;
      p_q <= pos_mem[p_raddr];
      if (pw0) pos_mem[pw0_addr] <= pw0_d;
      if (pw1) pos_mem[pw1_addr] <= pw1_d;
   end

   logic [IW-1:0] rid_idx;
   logic          id_ok, known;
   logic [PW:0]   c1, c2;
   logic [TIME_WIDTH-1:0] ka, kb, kc;
   logic [IW-1:0] cur_id;
   assign rid_idx = IW'(rid_ff);
   assign id_ok   = (32'(rid_ff) < 32'(ID_SPACE));
   assign known   = id_ok && present_ff[rid_idx];
   assign c1      = (PW+1)'({i_ff, 1'b1});
   assign c2      = c1 + 1'b1;
   assign ka      = ha_q[EW-1:IW];
   assign kb      = hb_q[EW-1:IW];
   assign kc      = cur_ff[EW-1:IW];
   assign cur_id  = cur_ff[IW-1:0];

   // sift bound: n slots
   logic [PW-1:0] lim;
   assign lim = count_ff;

   logic [TIME_WIDTH:0] dly_raw;
   logic [31:0] next_delay;
   always_comb begin
      dly_raw = {1'b0, top_ff[EW-1:IW]} - {1'b0, now_ff};
      if (count_ff == '0) next_delay = 32'hFFFF_FFFF;
      else if (top_ff[EW-1:IW] <= now_ff) next_delay = '0;
      else if ((TIME_WIDTH+1)'(dly_raw) > (TIME_WIDTH+1)'(33'h7FFF_FFFF))
         next_delay = 32'h7FFF_FFFF;
      else next_delay = 32'(dly_raw[TIME_WIDTH-1:0]);
   end

   always_comb begin
      state_in = state_ff; req_in = req_ff; rid_in = rid_ff; exp_in = exp_ff;
      now_in = now_ff; status_in = status_ff; fv_in = fv_ff; fid_in = fid_ff;
      more_in = more_ff; fired_any_in = fired_any_ff; i_in = i_ff;
      start_in = start_ff; cur_in = cur_ff; moved_in = moved_ff; up_in = up_ff;
      top_in = top_ff; present_in = present_ff; count_in = count_ff;
      ha_re = 1'b0; hb_re = 1'b0; ha_addr = i_ff; hb_addr = i_ff;
      hw0 = 1'b0; hw1 = 1'b0; hw0_addr = i_ff; hw1_addr = i_ff;
      hw0_d = cur_ff; hw1_d = cur_ff;
      pw0 = 1'b0; pw1 = 1'b0; pw0_addr = cur_id; pw1_addr = cur_id;
      pw0_d = i_ff; pw1_d = i_ff; p_raddr = rid_idx;
      case (state_ff)
         S_IDLE: begin
            // Look up the position of the incoming id while the beat is taken.
            p_raddr = IW'(req_tdata[7:0]);
            if (req_tvalid) begin
               req_in = req_tuser; rid_in = req_tdata[7:0];
               exp_in = req_tdata[8 +: TIME_WIDTH];
               now_in = req_tdata[40 +: TIME_WIDTH];
               status_in = iht_pkg::ST_OK; fv_in = 1'b0; fid_in = '0;
               more_in = 1'b0; fired_any_in = 1'b0;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            // p_q now holds position of rid (read issued with p_raddr last cycle)
            case (req_ff)
               iht_pkg::REQ_ADD: begin
                  if (!id_ok) begin
                     status_in = iht_pkg::ST_NOTFOUND; state_in = S_LASTRD;
                  end else if (known) begin
                     i_in = p_q;
                     cur_in = {exp_ff, rid_idx};
                     hw0 = 1'b1; hw0_addr = p_q; hw0_d = {exp_ff, rid_idx};
                     up_in = 1'b0; moved_in = 1'b0; state_in = S_SETUP;
                  end else if (count_ff >= PW'(HEAP_CAPACITY)) begin
                     status_in = iht_pkg::ST_FULL; state_in = S_LASTRD;
                  end else begin
                     i_in = AW'(count_ff); cur_in = {exp_ff, rid_idx};
                     hw0 = 1'b1; hw0_addr = AW'(count_ff); hw0_d = {exp_ff, rid_idx};
                     pw0 = 1'b1; pw0_addr = rid_idx; pw0_d = AW'(count_ff);
                     present_in[rid_idx] = 1'b1; count_in = count_ff + 1'b1;
                     up_in = 1'b1; state_in = S_SETUP;
                  end
               end
               iht_pkg::REQ_TICK: begin
                  start_in = AW'(count_ff - 1'b1);
                  state_in = S_TOPRD;
               end
               default: begin
                  if (!known) begin
                     status_in = iht_pkg::ST_NOTFOUND; state_in = S_LASTRD;
                  end else begin
                     if (req_ff == iht_pkg::REQ_FIRE) begin
                        fv_in = 1'b1; fid_in = rid_ff;
                     end
                     i_in = p_q; state_in = S_RDP;
                  end
               end
            endcase
         end
         S_RDP: begin
            // removal at i: read last entry
            ha_re = 1'b1; ha_addr = AW'(count_ff - 1'b1);
            hb_re = 1'b1; hb_addr = i_ff;
            state_in = S_SETUP; up_in = 1'b0; moved_in = 1'b0;
            cur_in = '0;
            more_in = 1'b1; // marker: removal pending, resolved in S_SETUP
         end
         S_SETUP: begin
            if (more_ff) begin
               // removal: hb_q is entry at i, ha_q is last entry
               more_in = 1'b0;
               present_in[hb_q[IW-1:0]] = 1'b0;
               count_in = count_ff - 1'b1;
               // The removed entry parks in the freed tail slot, where a tick
               // reads it back when it sends its beats.
               hw1 = 1'b1; hw1_addr = AW'(count_ff - 1'b1); hw1_d = hb_q;
               if (32'(i_ff) < 32'(count_ff - 1'b1)) begin
                  cur_in = ha_q;
                  hw0 = 1'b1; hw0_addr = i_ff; hw0_d = ha_q;
                  pw0 = 1'b1; pw0_addr = ha_q[IW-1:0]; pw0_d = i_ff;
                  state_in = S_DRD;
               end else begin
                  state_in = S_LASTRD;
               end
            end else begin
               state_in = up_ff ? S_URD : S_DRD;
            end
         end
         S_DRD: begin
            if (32'(c1) < 32'(lim)) begin
               ha_re = 1'b1; ha_addr = AW'(c1);
               hb_re = 1'b1; hb_addr = AW'(c2);
               state_in = S_DCMP;
            end else if (!moved_ff) begin
               up_in = 1'b1; state_in = S_URD;
            end else state_in = S_LASTRD;
         end
         S_DCMP: begin
            logic          pick_b;
            logic [EW-1:0] ch;
            logic [AW-1:0] ca;
            pick_b = (32'(c2) < 32'(lim)) && (kb < ka);
            ch = pick_b ? hb_q : ha_q;
            ca = pick_b ? AW'(c2) : AW'(c1);
            if (kc < ch[EW-1:IW]) begin
               state_in = moved_ff ? S_LASTRD : S_URD; up_in = 1'b1;
            end else begin
               hw0 = 1'b1; hw0_addr = i_ff; hw0_d = ch;
               hw1 = 1'b1; hw1_addr = ca; hw1_d = cur_ff;
               pw0 = 1'b1; pw0_addr = ch[IW-1:0]; pw0_d = i_ff;
               pw1 = 1'b1; pw1_addr = cur_id; pw1_d = ca;
               i_in = ca; moved_in = 1'b1; state_in = S_DRD;
            end
         end
         S_URD: begin
            if (i_ff == '0) state_in = S_LASTRD;
            else begin
               ha_re = 1'b1; ha_addr = AW'((i_ff - 1'b1) >> 1);
               state_in = S_UCMP;
            end
         end
         S_UCMP: begin
            if (ka < kc) state_in = S_LASTRD;
            else begin
               hw0 = 1'b1; hw0_addr = AW'((i_ff - 1'b1) >> 1); hw0_d = cur_ff;
               hw1 = 1'b1; hw1_addr = i_ff; hw1_d = ha_q;
               pw0 = 1'b1; pw0_addr = cur_id; pw0_d = AW'((i_ff - 1'b1) >> 1);
               pw1 = 1'b1; pw1_addr = ha_q[IW-1:0]; pw1_d = i_ff;
               i_in = AW'((i_ff - 1'b1) >> 1); state_in = S_URD;
            end
         end
         S_LASTRD: begin
            ha_re = 1'b1; ha_addr = '0; state_in = S_WR;
         end
         S_WR: begin
            top_in = ha_q;
            if (req_ff == iht_pkg::REQ_TICK) state_in = S_TOPCHK;
            else state_in = S_FIN;
         end
         S_TOPRD: begin
            ha_re = 1'b1; ha_addr = '0; state_in = S_WR;
         end
         S_TOPCHK: begin
            if (count_ff != '0 && top_ff[EW-1:IW] <= now_ff) begin
               // Pop the root; beats go out once the whole tick has settled.
               fired_any_in = 1'b1; i_in = '0; state_in = S_RDP;
            end else if (fired_any_ff) begin
               // The popped entries sit in the slots just above the final
               // count, the earliest one in the highest slot.
               ha_re = 1'b1; ha_addr = start_ff; state_in = S_FIN;
            end else begin
               fv_in = 1'b0; fid_in = '0; state_in = S_FIN;
            end
         end
         S_FIN: begin
            // For a tick that popped, ha_q holds the popped entry to report.
            if (req_ff == iht_pkg::REQ_TICK && fired_any_ff) begin
               fv_in = 1'b1; fid_in = 8'(ha_q[IW-1:0]);
               more_in = (32'(start_ff) > 32'(count_ff));
            end else more_in = 1'b0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               if (more_ff) begin
                  start_in = start_ff - 1'b1;
                  ha_re = 1'b1; ha_addr = start_ff - 1'b1;
                  state_in = S_FIN;
               end else state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; present_ff <= '0; count_ff <= '0;
         more_ff <= 1'b0; fired_any_ff <= 1'b0;
      end else begin
         state_ff <= state_in; present_ff <= present_in; count_ff <= count_in;
         more_ff <= more_in; fired_any_ff <= fired_any_in;
      end
      req_ff <= req_in; rid_ff <= rid_in; exp_ff <= exp_in; now_ff <= now_in;
      status_ff <= status_in; fv_ff <= fv_in; fid_ff <= fid_in; i_ff <= i_in;
      start_ff <= start_in; cur_ff <= cur_in; moved_ff <= moved_in; up_ff <= up_in;
      top_ff <= top_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tuser  = fv_ff;
   assign rsp_tlast  = !more_ff;
   assign rsp_tdata  = {7'b0, next_delay, 7'(count_ff), status_ff, fid_ff};

   // A beat is only offered from the output state.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("output and input overlap");
   // Count never exceeds capacity.
   assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(HEAP_CAPACITY)) else $error("heap count overflow");
   // A stalled beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("beat changed");
endmodule
